// ===== sv/tsr_pkg.sv =====
// Shared constants, comparator operation codes and operand bundle for the stream reassembler.
`timescale 1ns / 1ps

package tsr_pkg;

  // Ring depth in bytes; a power of two, so the slot is the low bits of a position.
  localparam int CAPACITY   = 64;
  // Width of an absolute stream position.
  localparam int INDEX_BITS = 48;

  localparam int SLOT_W  = $clog2(CAPACITY);
  // Window sums are kept one bit wider so they never wrap.
  localparam int SUM_W   = INDEX_BITS + 1;
  localparam int CNT_W   = 7;
  localparam int LEN_W   = 16;
  localparam int BYTE_W  = 8;

  // Operations of the shared comparator; each one is "a >= b".
  typedef enum logic [2:0] {
    CMP_RD_NEXT,
    CMP_START_WEND,
    CMP_SEGEND_NEXT,
    CMP_WEND_SEGEND,
    CMP_POS_NEXT,
    CMP_POS_WEND
  } tsr_cmp_op_e;

  // All values the comparator may be asked to weigh, zero-extended to SUM_W.
  typedef struct packed {
    logic [SUM_W-1:0] seg_begin;
    logic [SUM_W-1:0] seg_end;
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] rd;
    logic [SUM_W-1:0] nxt;
    logic [SUM_W-1:0] wend;
  } tsr_cmp_opnd_t;

endpackage

// ===== sv/tsr_cmp_unit.sv =====
// Shared wide magnitude comparator with its operand selection.
`timescale 1ns / 1ps

module tsr_cmp_unit import tsr_pkg::*; (
  input  tsr_cmp_op_e   op_i,
  input  tsr_cmp_opnd_t opnd_i,
  output logic          ge_o
);

  logic [SUM_W-1:0] a;
  logic [SUM_W-1:0] b;

  // Pick the operand pair for the requested operation.
  always_comb begin
    case (op_i)
      CMP_RD_NEXT: begin
        a = opnd_i.rd;
        b = opnd_i.nxt;
      end
      CMP_START_WEND: begin
        a = opnd_i.seg_begin;
        b = opnd_i.wend;
      end
      CMP_SEGEND_NEXT: begin
        a = opnd_i.seg_end;
        b = opnd_i.nxt;
      end
      CMP_WEND_SEGEND: begin
        a = opnd_i.wend;
        b = opnd_i.seg_end;
      end
      CMP_POS_NEXT: begin
        a = opnd_i.pos;
        b = opnd_i.nxt;
      end
      CMP_POS_WEND: begin
        a = opnd_i.pos;
        b = opnd_i.wend;
      end
      default: begin
        a = opnd_i.rd;
        b = opnd_i.nxt;
      end
    endcase
  end

  // One unsigned compare serves every window test.
  assign ge_o = (a >= b);

endmodule

// ===== sv/tsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/tcp_stream_reassembler_core.sv =====
// Stream reassembler: windowed byte ring with in-order release, under a small sequencer.
//
// Each request carries at most one byte of a segment. The block takes one request at a time
// and stalls its input until the last result of that request has been loaded into the output
// register. After acceptance the clamp step clamps the consumer count and forms the window end,
// a segment's first request then runs up to three drop and end-of-stream tests, and every
// request runs one or two window tests on the byte, the second of which writes it if it fits;
// all of these share one 49-bit comparator, one test per cycle. Release of each byte then takes
// a valid-bit check while the byte RAM read is issued, then the release of the registered read
// data; when nothing is released, the check is followed by the lone empty result. A stalled
// output holds the release. There is no clearing pass after reset: the ring's valid marks
// are flip-flops cleared by reset.
`timescale 1ns / 1ps

module tcp_stream_reassembler_core import tsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_BITS-1:0] seg_start_i,
  input  logic [LEN_W-1:0]      seg_length_i,
  input  logic [LEN_W-1:0]      offset_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  seg_last_i,
  input  logic                  eof_flag_i,
  input  logic [INDEX_BITS-1:0] read_total_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic                  byte_valid_o,
  output logic                  run_last_o,
  output logic                  stream_ended_o,
  output logic [CNT_W-1:0]      pending_count_o,
  output logic [INDEX_BITS-1:0] next_position_o
);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLAMP = 4'd1;
  localparam logic [3:0] S_DROP  = 4'd2;
  localparam logic [3:0] S_LATE  = 4'd3;
  localparam logic [3:0] S_EOF   = 4'd4;
  localparam logic [3:0] S_POSLO = 4'd5;
  localparam logic [3:0] S_POSHI = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_NONE  = 4'd9;

  // Control state.
  logic [3:0]            state_q, state_d;
  logic [INDEX_BITS-1:0] next_q, next_d;
  logic [CNT_W-1:0]      pending_q, pending_d;
  logic                  eof_seen_q, eof_seen_d;
  logic [INDEX_BITS-1:0] eof_pos_q, eof_pos_d;
  logic                  admitted_q, admitted_d;
  logic                  ended_q, ended_d;
  logic [CAPACITY-1:0]   valid_q, valid_d;
  logic                  out_valid_q, out_valid_d;

  // Request held while it is worked on.
  logic [INDEX_BITS-1:0] start_q, start_d;
  logic [SUM_W-1:0]      seg_end_q, seg_end_d;
  logic [SUM_W-1:0]      pos_q, pos_d;
  logic [INDEX_BITS-1:0] rd_q, rd_d;
  logic [SUM_W-1:0]      wend_q, wend_d;
  logic [BYTE_W-1:0]     data_q, data_d;
  logic                  eof_q, eof_d;
  logic                  has_byte_q, has_byte_d;
  logic                  first_q, first_d;

  // Output register.
  logic [BYTE_W-1:0]     out_byte_q, out_byte_d;
  logic                  byte_valid_q, byte_valid_d;
  logic                  run_last_q, run_last_d;
  logic                  out_ended_q, out_ended_d;
  logic [CNT_W-1:0]      out_pending_q, out_pending_d;
  logic [INDEX_BITS-1:0] out_next_q, out_next_d;

  // Shared comparator and byte ring.
  tsr_cmp_op_e           cmp_op;
  tsr_cmp_opnd_t         cmp_opnd;
  logic                  cmp_ge;
  logic                  ram_we;
  logic [BYTE_W-1:0]     ram_rdata;

  logic [SLOT_W-1:0]     pos_slot;
  logic [SLOT_W-1:0]     next_slot;
  logic [INDEX_BITS-1:0] next_inc;
  logic [SLOT_W-1:0]     next_inc_slot;
  logic                  out_free;
  logic                  run_done;

  assign pos_slot      = pos_q[SLOT_W-1:0];
  assign next_slot     = next_q[SLOT_W-1:0];
  assign next_inc      = next_q + INDEX_BITS'(1);
  assign next_inc_slot = next_inc[SLOT_W-1:0];
  assign out_free      = !out_valid_q || !out_stall_i;

  // Operands offered to the comparator.
  assign cmp_opnd.seg_begin = SUM_W'(start_q);
  assign cmp_opnd.seg_end   = seg_end_q;
  assign cmp_opnd.pos       = pos_q;
  assign cmp_opnd.rd        = SUM_W'(rd_q);
  assign cmp_opnd.nxt       = SUM_W'(next_q);
  assign cmp_opnd.wend      = wend_q;

  tsr_cmp_unit u_cmp (
    .op_i   (cmp_op),
    .opnd_i (cmp_opnd),
    .ge_o   (cmp_ge)
  );

  tsr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_slot),
    .wdata_i (data_q),
    .raddr_i (next_slot),
    .rdata_o (ram_rdata)
  );

  // Sequencer and datapath updates.
  always_comb begin
    state_d       = state_q;
    next_d        = next_q;
    pending_d     = pending_q;
    eof_seen_d    = eof_seen_q;
    eof_pos_d     = eof_pos_q;
    admitted_d    = admitted_q;
    ended_d       = ended_q;
    valid_d       = valid_q;
    out_valid_d   = out_valid_q && out_stall_i;
    start_d       = start_q;
    seg_end_d     = seg_end_q;
    pos_d         = pos_q;
    rd_d          = rd_q;
    wend_d        = wend_q;
    data_d        = data_q;
    eof_d         = eof_q;
    has_byte_d    = has_byte_q;
    first_d       = first_q;
    out_byte_d    = out_byte_q;
    byte_valid_d  = byte_valid_q;
    run_last_d    = run_last_q;
    out_ended_d   = out_ended_q;
    out_pending_d = out_pending_q;
    out_next_d    = out_next_q;
    cmp_op        = CMP_RD_NEXT;
    ram_we        = 1'b0;
    run_done      = 1'b0;

    case (state_q)
      // Capture the request and form the segment end and byte position.
      S_IDLE: begin
        if (in_valid_i) begin
          start_d    = seg_start_i;
          seg_end_d  = SUM_W'(seg_start_i) + SUM_W'(seg_length_i);
          pos_d      = SUM_W'(seg_start_i) + SUM_W'(offset_i);
          rd_d       = read_total_i;
          data_d     = data_byte_i;
          eof_d      = eof_flag_i;
          has_byte_d = (offset_i < seg_length_i);
          first_d    = (offset_i == '0);
          state_d    = S_CLAMP;
        end
      end
      // Clamp the consumer count to the next position and set the window end.
      S_CLAMP: begin
        cmp_op  = CMP_RD_NEXT;
        wend_d  = (cmp_ge ? SUM_W'(next_q) : SUM_W'(rd_q)) + SUM_W'(CAPACITY);
        state_d = first_q ? S_DROP : S_POSLO;
      end
      // A segment starting at or beyond the window end is dropped.
      S_DROP: begin
        cmp_op = CMP_START_WEND;
        if (cmp_ge) begin
          admitted_d = 1'b0;
          state_d    = S_POSLO;
        end else begin
          state_d = S_LATE;
        end
      end
      // A segment ending before the next position is dropped too.
      S_LATE: begin
        cmp_op     = CMP_SEGEND_NEXT;
        admitted_d = cmp_ge;
        state_d    = cmp_ge ? S_EOF : S_POSLO;
      end
      // An end-of-stream segment that fits the window records its end.
      S_EOF: begin
        cmp_op = CMP_WEND_SEGEND;
        if (cmp_ge && eof_q) begin
          eof_seen_d = 1'b1;
          eof_pos_d  = seg_end_q[INDEX_BITS-1:0];
        end
        state_d = S_POSLO;
      end
      // The byte must not lie before the next position.
      S_POSLO: begin
        cmp_op  = CMP_POS_NEXT;
        state_d = (admitted_q && has_byte_q && cmp_ge) ? S_POSHI : S_DRAIN;
      end
      // The byte must lie before the window end; a slot already held is kept.
      S_POSHI: begin
        cmp_op = CMP_POS_WEND;
        if (!cmp_ge && !valid_q[pos_slot]) begin
          ram_we            = 1'b1;
          valid_d[pos_slot] = 1'b1;
          pending_d         = pending_q + CNT_W'(1);
        end
        state_d = S_DRAIN;
      end
      // Check the slot of the next position; the RAM read runs this cycle.
      S_DRAIN: begin
        state_d = valid_q[next_slot] ? S_EMIT : S_NONE;
      end
      // Release one byte once the output register is free.
      S_EMIT: begin
        if (out_free) begin
          run_done           = !valid_q[next_inc_slot];
          valid_d[next_slot] = 1'b0;
          next_d             = next_inc;
          pending_d          = pending_q - CNT_W'(1);
          ended_d            = ended_q || (eof_seen_q && (next_inc == eof_pos_q));
          out_valid_d        = 1'b1;
          out_byte_d         = ram_rdata;
          byte_valid_d       = 1'b1;
          run_last_d         = run_done;
          out_ended_d        = ended_d;
          out_pending_d      = pending_d;
          out_next_d         = next_d;
          state_d            = run_done ? S_IDLE : S_DRAIN;
        end
      end
      // Nothing to release: give one empty result.
      S_NONE: begin
        if (out_free) begin
          ended_d       = ended_q || (eof_seen_q && (next_q == eof_pos_q));
          out_valid_d   = 1'b1;
          out_byte_d    = '0;
          byte_valid_d  = 1'b0;
          run_last_d    = 1'b1;
          out_ended_d   = ended_d;
          out_pending_d = pending_q;
          out_next_d    = next_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_q      <= '0;
      pending_q   <= '0;
      eof_seen_q  <= 1'b0;
      eof_pos_q   <= '0;
      admitted_q  <= 1'b0;
      ended_q     <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      pending_q   <= pending_d;
      eof_seen_q  <= eof_seen_d;
      eof_pos_q   <= eof_pos_d;
      admitted_q  <= admitted_d;
      ended_q     <= ended_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    start_q       <= start_d;
    seg_end_q     <= seg_end_d;
    pos_q         <= pos_d;
    rd_q          <= rd_d;
    wend_q        <= wend_d;
    data_q        <= data_d;
    eof_q         <= eof_d;
    has_byte_q    <= has_byte_d;
    first_q       <= first_d;
    out_byte_q    <= out_byte_d;
    byte_valid_q  <= byte_valid_d;
    run_last_q    <= run_last_d;
    out_ended_q   <= out_ended_d;
    out_pending_q <= out_pending_d;
    out_next_q    <= out_next_d;
  end

  // The final-item marker of a segment carries no information for this block.
  logic unused_seg_last;
  assign unused_seg_last = seg_last_i;

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_valid_o    = byte_valid_q;
  assign run_last_o      = run_last_q;
  assign stream_ended_o  = out_ended_q;
  assign pending_count_o = out_pending_q;
  assign next_position_o = out_next_q;

endmodule
